@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL files of the overlap filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/profilt_pkg.sv @@
// Package: status codes, stream payload layout and shared types of the overlap filter.
`timescale 1ns / 1ps

package profilt_pkg;

    // Result status codes
    typedef logic [2:0] status_t;
    localparam status_t STATUS_OK       = 3'd0;
    localparam status_t STATUS_DISABLED = 3'd1;
    localparam status_t STATUS_EMPTY    = 3'd2;
    localparam status_t STATUS_OVERLAP  = 3'd3;
    localparam status_t STATUS_FULL     = 3'd4;

    // Width of every input field that carries a coordinate or a size
    localparam int FIELD_W = 16;

    // Input tdata layout, lowest bit first
    localparam int EN_BIT     = 0;
    localparam int X_LSB      = 1;
    localparam int Y_LSB      = 17;
    localparam int W_LSB      = 33;
    localparam int H_LSB      = 49;
    localparam int SHIFT_LSB  = 65;
    localparam int IN_DATA_W  = 88;

    // Output tdata layout
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;
    localparam int OUT_DATA_W = 8;

endpackage

@@ rtl/core/placed_rect_overlap_filter.sv @@
// Top level: table of placed rectangles with overlap filtering and canvas scroll.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// Input stream (s_*): one transfer is one item. s_tuser[0] selects the function:
// 0 offers a rectangle for placement, 1 scrolls the canvas up by shift_amount.
// Output stream (m_*): exactly one transfer per input item, in order, carrying the
// status code and the number of stored rectangles after the item.
// Timing: a scroll or an enabled, non-empty offer walks the whole table, issuing one
// entry read per cycle from the table memory. An offer's entries pass through one
// shared datapath (end sums, min/max, one multiplier pair, one compare); a scroll
// moves or drops each entry in stage 1. The block then drains the datapath and posts
// the result. A disabled or empty offer skips the walk and the drain. One item is
// in work at a time; s_tready is high only between items.
// The result sits in an output register: the next item is taken while it waits, and
// a stalled m_tready only holds the block once a second result is ready to post.
// Reset empties the table at once (valid bits cleared); no clearing pass is needed.
module placed_rect_overlap_filter #(
    parameter int MAX_RECTS  = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: enable_flag, rect_x[15:0], rect_y[15:0], rect_w[15:0], rect_h[15:0],
    //        shift_amount[15:0], zero fill
    input  logic [profilt_pkg::IN_DATA_W-1:0]   s_tdata,
    // tuser: func
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: status[2:0], entry_count[4:0]
    output logic [profilt_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int CW   = COORD_BITS;
    localparam int EW   = CW + 1;
    localparam int PW   = 2 * EW;
    localparam int CMPW = PW + 3;
    localparam int MW   = 4 * CW;
    localparam int IW   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNTW = $clog2(MAX_RECTS + 1);
    localparam int SW   = (CW > profilt_pkg::FIELD_W) ? CW : profilt_pkg::FIELD_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // Control registers
    logic [1:0]              state_reg, state_next;
    logic [IW-1:0]           cnt_reg, cnt_next;
    logic [MAX_RECTS-1:0]    valid_reg, valid_next;
    logic [CNTW-1:0]         count_reg, count_next;
    logic                    slot_found_reg, slot_found_next;
    logic                    hit_reg, hit_next;
    logic                    p1_live_reg, p1_live_next;
    logic                    p2_live_reg, p2_live_next;
    logic                    p3_live_reg, p3_live_next;
    logic                    p4_live_reg, p4_live_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // Payload registers
    logic                    func_reg;
    logic                    place_reg;
    profilt_pkg::status_t    pend_status_reg;
    logic [CW-1:0]           x_reg, y_reg, w_reg, h_reg;
    logic [EW-1:0]           xe_reg, ye_reg;
    logic [profilt_pkg::FIELD_W-1:0] shift_reg;
    logic [IW-1:0]           slot_reg;
    logic [IW-1:0]           p1_idx_reg;
    logic [MW-1:0]           mem_rd_reg;
    logic [CW-1:0]           p2_sx_reg, p2_sy_reg;
    logic [EW-1:0]           p2_sxe_reg, p2_sye_reg;
    logic [EW-1:0]           p3_ux_reg, p3_uy_reg, p3_ix_reg, p3_iy_reg;
    logic [PW-1:0]           p4_u_reg, p4_i_reg;
    profilt_pkg::status_t    out_status_reg;
    logic [profilt_pkg::COUNT_W-1:0] out_count_reg;

    // Rectangle table: {h, w, y, x}
    logic [MW-1:0]           mem [MAX_RECTS];

    // Input field extraction
    logic                    in_func, in_en;
    logic [CW-1:0]           in_x, in_y, in_w, in_h;
    logic                    accept;

    assign in_func = s_tuser[0];
    assign in_en   = s_tdata[profilt_pkg::EN_BIT];
    assign in_x    = CW'(s_tdata[profilt_pkg::X_LSB +: profilt_pkg::FIELD_W]);
    assign in_y    = CW'(s_tdata[profilt_pkg::Y_LSB +: profilt_pkg::FIELD_W]);
    assign in_w    = CW'(s_tdata[profilt_pkg::W_LSB +: profilt_pkg::FIELD_W]);
    assign in_h    = CW'(s_tdata[profilt_pkg::H_LSB +: profilt_pkg::FIELD_W]);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Any datapath stage still holding a live entry
    logic pipe_busy;
    assign pipe_busy = p1_live_reg || p2_live_reg || p3_live_reg || p4_live_reg;

    // Stage 1: fields of the entry read last cycle
    logic [CW-1:0] rd_x, rd_y, rd_w, rd_h;
    assign rd_x = mem_rd_reg[CW-1:0];
    assign rd_y = mem_rd_reg[2*CW-1:CW];
    assign rd_w = mem_rd_reg[3*CW-1:2*CW];
    assign rd_h = mem_rd_reg[4*CW-1:3*CW];

    // Scroll: drop or move the entry in stage 1
    logic scroll_live, scroll_drop;
    logic [CW-1:0] y_moved;
    assign scroll_live = p1_live_reg && func_reg;
    assign scroll_drop = SW'(rd_y) < SW'(shift_reg);
    assign y_moved     = CW'(SW'(rd_y) - SW'(shift_reg));

    // Stage 2: bounding box and intersection extents
    logic [EW-1:0] ux, uy, ix, iy;
    logic [EW-1:0] lo_x, hi_x, lo_y, hi_y, bmax_x, bmin_x, bmax_y, bmin_y;
    always_comb
    begin
        bmax_x = (xe_reg > p2_sxe_reg) ? xe_reg : p2_sxe_reg;
        bmin_x = (x_reg < p2_sx_reg) ? EW'(x_reg) : EW'(p2_sx_reg);
        bmax_y = (ye_reg > p2_sye_reg) ? ye_reg : p2_sye_reg;
        bmin_y = (y_reg < p2_sy_reg) ? EW'(y_reg) : EW'(p2_sy_reg);
        lo_x   = (x_reg > p2_sx_reg) ? EW'(x_reg) : EW'(p2_sx_reg);
        hi_x   = (xe_reg < p2_sxe_reg) ? xe_reg : p2_sxe_reg;
        lo_y   = (y_reg > p2_sy_reg) ? EW'(y_reg) : EW'(p2_sy_reg);
        hi_y   = (ye_reg < p2_sye_reg) ? ye_reg : p2_sye_reg;
        ux     = bmax_x - bmin_x;
        uy     = bmax_y - bmin_y;
        ix     = (hi_x > lo_x) ? (hi_x - lo_x) : '0;
        iy     = (hi_y > lo_y) ? (hi_y - lo_y) : '0;
    end

    // Stage 4: 4*U < 5*I
    logic [CMPW-1:0] four_u, five_i;
    logic            too_close;
    assign four_u    = CMPW'({p4_u_reg, 2'b00});
    assign five_i    = CMPW'({p4_i_reg, 2'b00}) + CMPW'(p4_i_reg);
    assign too_close = p4_live_reg && (four_u < five_i);

    // Final decision
    logic                 out_free, store;
    profilt_pkg::status_t final_status;
    assign out_free = !m_tvalid_reg || m_tready;
    always_comb
    begin
        store = 1'b0;
        if (!place_reg)
        begin
            final_status = pend_status_reg;
        end
        else if (hit_reg)
        begin
            final_status = profilt_pkg::STATUS_OVERLAP;
        end
        else if (!slot_found_reg)
        begin
            final_status = profilt_pkg::STATUS_FULL;
        end
        else
        begin
            final_status = profilt_pkg::STATUS_OK;
            store        = 1'b1;
        end
    end

    // Memory write port: scroll write-back or a new entry
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [MW-1:0] mem_wd;
    logic          finish_go;
    assign finish_go = (state_reg == ST_FINISH) && out_free;
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = p1_idx_reg;
        mem_wd = {rd_h, rd_w, y_moved, rd_x};
        if (scroll_live && !scroll_drop)
        begin
            mem_we = 1'b1;
        end
        else if (finish_go && store)
        begin
            mem_we = 1'b1;
            mem_wa = slot_reg;
            mem_wd = {h_reg, w_reg, y_reg, x_reg};
        end
    end

    // Sequencer and table bookkeeping
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        slot_found_next = slot_found_reg;
        hit_next        = hit_reg || too_close;
        p1_live_next    = (state_reg == ST_WALK) && valid_reg[cnt_reg];
        p2_live_next    = p1_live_reg && !func_reg;
        p3_live_next    = p2_live_reg;
        p4_live_next    = p3_live_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        if (scroll_live && scroll_drop)
        begin
            valid_next[p1_idx_reg] = 1'b0;
            count_next             = count_reg - CNTW'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next        = '0;
                    slot_found_next = 1'b0;
                    hit_next        = 1'b0;
                    if (!in_func && (!in_en || in_w == '0 || in_h == '0))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (!valid_reg[cnt_reg] && !slot_found_reg)
                begin
                    slot_found_next = 1'b1;
                end
                if (cnt_reg == IW'(MAX_RECTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                    if (store)
                    begin
                        valid_next[slot_reg] = 1'b1;
                        count_next           = count_reg + CNTW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            valid_reg      <= '0;
            count_reg      <= '0;
            slot_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            p1_live_reg    <= 1'b0;
            p2_live_reg    <= 1'b0;
            p3_live_reg    <= 1'b0;
            p4_live_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            slot_found_reg <= slot_found_next;
            hit_reg        <= hit_next;
            p1_live_reg    <= p1_live_next;
            p2_live_reg    <= p2_live_next;
            p3_live_reg    <= p3_live_next;
            p4_live_reg    <= p4_live_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= in_func;
            place_reg <= !in_func && in_en && (in_w != '0) && (in_h != '0);
            if (in_func || (in_en && in_w != '0 && in_h != '0))
            begin
                pend_status_reg <= profilt_pkg::STATUS_OK;
            end
            else if (!in_en)
            begin
                pend_status_reg <= profilt_pkg::STATUS_DISABLED;
            end
            else
            begin
                pend_status_reg <= profilt_pkg::STATUS_EMPTY;
            end
            x_reg     <= in_x;
            y_reg     <= in_y;
            w_reg     <= in_w;
            h_reg     <= in_h;
            xe_reg    <= EW'(in_x) + EW'(in_w);
            ye_reg    <= EW'(in_y) + EW'(in_h);
            shift_reg <= s_tdata[profilt_pkg::SHIFT_LSB +: profilt_pkg::FIELD_W];
        end
        if (state_reg == ST_WALK && !valid_reg[cnt_reg] && !slot_found_reg)
        begin
            slot_reg <= cnt_reg;
        end
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_rd_reg <= mem[cnt_reg];
    end

    // Shared datapath stages
    always_ff @(posedge clk)
    begin
        p1_idx_reg <= cnt_reg;
        p2_sx_reg  <= rd_x;
        p2_sy_reg  <= rd_y;
        p2_sxe_reg <= EW'(rd_x) + EW'(rd_w);
        p2_sye_reg <= EW'(rd_y) + EW'(rd_h);
        p3_ux_reg  <= ux;
        p3_uy_reg  <= uy;
        p3_ix_reg  <= ix;
        p3_iy_reg  <= iy;
        p4_u_reg   <= PW'(p3_ux_reg) * PW'(p3_uy_reg);
        p4_i_reg   <= PW'(p3_ix_reg) * PW'(p3_iy_reg);
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (finish_go)
        begin
            out_status_reg <= final_status;
            out_count_reg  <= profilt_pkg::COUNT_W'(count_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_count_reg, out_status_reg};

    // Checks
    `ASSERT_IMP(a_count_matches, clk, rst_n, 1'b1, int'(count_reg) == $countones(valid_reg))
    `ASSERT_IMP(a_finish_drained, clk, rst_n, state_reg == ST_FINISH, !pipe_busy)
    `ASSERT_IMP(a_store_free_slot, clk, rst_n, finish_go && store, !valid_reg[slot_reg])
    `ASSERT_NXT(a_disabled_short, clk, rst_n, accept && !in_func && !in_en, state_reg == ST_FINISH)

endmodule

@@ test/tb_placed_rect_overlap_filter.sv @@
// Testbench for the placed rectangle overlap filter: directed and random stream checks.
`timescale 1ns / 1ps

module tb_placed_rect_overlap_filter;

    localparam int NUM_SLOTS     = 16;
    localparam int IDLE_PCT      = 18;
    localparam int RANDOM_ITEMS  = 1025;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;
    localparam bit FUNC_PLACE    = 1'b0;
    localparam bit FUNC_SCROLL   = 1'b1;

    typedef struct packed {
        profilt_pkg::status_t status;
        logic [4:0]           count;
    } place_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [profilt_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [0:0]                         s_tuser = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [profilt_pkg::OUT_DATA_W-1:0] m_tdata;

    // Shadow copy of the rectangle table
    bit          slot_used [NUM_SLOTS];
    logic [15:0] slot_x [NUM_SLOTS];
    logic [15:0] slot_y [NUM_SLOTS];
    logic [15:0] slot_w [NUM_SLOTS];
    logic [15:0] slot_h [NUM_SLOTS];

    place_result_t pending_results[$];
    int            error_count = 0;
    int            cycle_count = 0;
    bit            no_idle = 1'b0;

    placed_rect_overlap_filter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        $display("ERROR @%0t: %s expected %0d got %0d", $realtime, what, exp_val, got_val);
        error_count++;
    endtask

    // True when the offer covers too much of stored slot idx: 4*U < 5*I
    function automatic bit crowds_slot(input int idx, input logic [15:0] x, y, w, h);
        longint unsigned ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        longint unsigned span_x, span_y, ovl_x, ovl_y, ovl_area;
        ax0 = x;
        ay0 = y;
        ax1 = ax0 + w;
        ay1 = ay0 + h;
        bx0 = slot_x[idx];
        by0 = slot_y[idx];
        bx1 = bx0 + slot_w[idx];
        by1 = by0 + slot_h[idx];
        span_x = ((ax1 > bx1) ? ax1 : bx1) - ((ax0 < bx0) ? ax0 : bx0);
        span_y = ((ay1 > by1) ? ay1 : by1) - ((ay0 < by0) ? ay0 : by0);
        ovl_x = (ax0 > bx0) ? ax0 : bx0;
        ovl_y = (ay0 > by0) ? ay0 : by0;
        ovl_area = 0;
        if (((ax1 < bx1) ? ax1 : bx1) > ovl_x && ((ay1 < by1) ? ay1 : by1) > ovl_y)
            ovl_area = (((ax1 < bx1) ? ax1 : bx1) - ovl_x) * (((ay1 < by1) ? ay1 : by1) - ovl_y);
        return (4 * span_x * span_y) < (5 * ovl_area);
    endfunction

    // Apply one item to the shadow table and return the expected result
    function automatic place_result_t place_or_scroll(input bit func, input bit en,
                                                      input logic [15:0] x, y, w, h, shift);
        place_result_t res;
        int free_slot;
        int used;
        res.status = profilt_pkg::STATUS_OK;
        free_slot = -1;
        used = 0;
        if (func == FUNC_SCROLL)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (slot_used[i])
                begin
                    if (slot_y[i] < shift)
                        slot_used[i] = 1'b0;
                    else
                        slot_y[i] = slot_y[i] - shift;
                end
            end
        end
        else if (!en)
            res.status = profilt_pkg::STATUS_DISABLED;
        else if (w == 0 || h == 0)
            res.status = profilt_pkg::STATUS_EMPTY;
        else
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (slot_used[i])
                begin
                    if (crowds_slot(i, x, y, w, h))
                    begin
                        res.status = profilt_pkg::STATUS_OVERLAP;
                        break;
                    end
                end
                else if (free_slot < 0)
                    free_slot = i;
            end
            if (res.status == profilt_pkg::STATUS_OK)
            begin
                if (free_slot < 0)
                    res.status = profilt_pkg::STATUS_FULL;
                else
                begin
                    slot_used[free_slot] = 1'b1;
                    slot_x[free_slot] = x;
                    slot_y[free_slot] = y;
                    slot_w[free_slot] = w;
                    slot_h[free_slot] = h;
                end
            end
        end
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_used[i])
                used++;
        res.count = used[4:0];
        return res;
    endfunction

    // Send one item, with random idle cycles ahead of it
    task automatic send_item(input bit func, input bit en,
                             input logic [15:0] x, y, w, h, shift);
        place_result_t exp_res;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {7'b0, shift, h, w, y, x, en};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        exp_res = place_or_scroll(func, en, x, y, w, h, shift);
        pending_results = {pending_results, exp_res};
    endtask

    // Result side: check each transfer, then choose the next ready
    always @(posedge clk)
    begin
        place_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, status", -1, m_tdata[2:0]);
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_tdata[2:0] !== exp_res.status)
                    report_mismatch("status", exp_res.status, m_tdata[2:0]);
                if (m_tdata[7:3] !== exp_res.count)
                    report_mismatch("entry_count", exp_res.count, m_tdata[7:3]);
            end
        end
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic logic [15:0] rand16();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] clamp16(input int v, input int lo);
        if (v < lo)
            return 16'(lo);
        if (v > 65535)
            return 16'hFFFF;
        return 16'(v);
    endfunction

    // Disabled wins over empty, empty checked on either size
    task automatic test_reject_codes();
        send_item(FUNC_SCROLL, 1'b1, rand16(), rand16(), rand16(), rand16(), 16'd0);
        send_item(FUNC_PLACE, 1'b0, 16'd3, 16'd3, 16'd0, 16'd7, rand16());
        send_item(FUNC_PLACE, 1'b1, 16'd3, 16'd3, 16'd0, 16'd5, rand16());
        send_item(FUNC_PLACE, 1'b1, 16'd3, 16'd3, 16'd5, 16'd0, rand16());
    endtask

    // Threshold edge, far corner without wrap, touching edges
    task automatic test_overlap_threshold();
        send_item(FUNC_PLACE, 1'b1, 16'd0, 16'd0, 16'd10, 16'd10, 16'd0);
        send_item(FUNC_PLACE, 1'b1, 16'd0, 16'd0, 16'd10, 16'd9, 16'd0);
        send_item(FUNC_PLACE, 1'b1, 16'd0, 16'd0, 16'd10, 16'd8, 16'd0);
        send_item(FUNC_PLACE, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(FUNC_PLACE, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        send_item(FUNC_PLACE, 1'b1, 16'd10, 16'd0, 16'd10, 16'd10, 16'd0);
    endtask

    // Fill every slot, then one clean offer that finds no room
    task automatic test_table_full();
        for (int k = 0; k < 12; k++)
            send_item(FUNC_PLACE, 1'b1, 16'(1000 + 100 * k), 16'(100 + k),
                      16'd50, 16'd50, rand16());
        send_item(FUNC_PLACE, 1'b1, 16'd40000, 16'd40000, 16'd5, 16'd5, 16'd0);
    endtask

    // Row equal to shift is kept at zero, lower rows dropped, then drop everything
    task automatic test_scroll_drop();
        send_item(FUNC_SCROLL, 1'b0, rand16(), rand16(), 16'd0, rand16(), 16'd105);
        send_item(FUNC_SCROLL, 1'b1, rand16(), rand16(), rand16(), 16'd0, 16'hFFFF);
    endtask

    task automatic test_random_traffic();
        int pick;
        int idx;
        int tries;
        logic [15:0] x, y, w, h, shift;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n >= 300 && n < 500);
            pick = $urandom_range(0, 99);
            shift = rand16();
            if (pick < 8)
            begin
                // scroll with mostly small amounts, some extremes
                case ($urandom_range(0, 9))
                    0, 1:    shift = 16'd0;
                    2:       shift = 16'hFFFF;
                    3:       shift = rand16();
                    default: shift = 16'($urandom_range(1, 64));
                endcase
                send_item(FUNC_SCROLL, 1'($urandom_range(0, 1)), rand16(), rand16(),
                          rand16(), rand16(), shift);
            end
            else if (pick < 13)
                send_item(FUNC_PLACE, 1'b0, rand16(), rand16(), rand16(), rand16(), shift);
            else if (pick < 18)
            begin
                w = rand16();
                h = rand16();
                if ($urandom_range(0, 1))
                    w = 16'd0;
                else
                    h = 16'd0;
                send_item(FUNC_PLACE, 1'b1, rand16(), rand16(), w, h, shift);
            end
            else
            begin
                // fresh rectangle, or a near copy of a stored one
                if ($urandom_range(0, 63) < 7)
                begin
                    x = rand16();
                    y = rand16();
                    w = 16'($urandom_range(1, 65535));
                    h = 16'($urandom_range(1, 65535));
                end
                else
                begin
                    x = 16'($urandom_range(0, 2047));
                    y = 16'($urandom_range(0, 255));
                    w = 16'($urandom_range(1, 96));
                    h = 16'($urandom_range(1, 96));
                end
                if (pick < 40)
                begin
                    idx = -1;
                    for (tries = 0; tries < 8 && idx < 0; tries++)
                    begin
                        idx = $urandom_range(0, NUM_SLOTS - 1);
                        if (!slot_used[idx])
                            idx = -1;
                    end
                    if (idx >= 0)
                    begin
                        x = clamp16(int'(slot_x[idx]) + $urandom_range(0, 4) - 2, 0);
                        y = clamp16(int'(slot_y[idx]) + $urandom_range(0, 4) - 2, 0);
                        w = clamp16(int'(slot_w[idx]) + $urandom_range(0, 4) - 2, 1);
                        h = clamp16(int'(slot_h[idx]) + $urandom_range(0, 4) - 2, 1);
                    end
                end
                send_item(FUNC_PLACE, 1'b1, x, y, w, h, shift);
            end
        end
        no_idle = 1'b0;
    endtask

    // Main sequence
    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
            slot_used[i] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reject_codes();
        test_overlap_threshold();
        test_table_full();
        test_scroll_drop();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
